// File: hdl/sfvs_pkg.sv
// ============================================================================
// sfvs_pkg
// Shared types, constants and helpers for the stream-function velocity stencil.
// ============================================================================
package sfvs_pkg;

    // Default grid capacity
    localparam int DEF_MAX_PADDED_COLUMNS = 256;
    localparam int DEF_MAX_PADDED_ROWS    = 256;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERIOR_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERIOR_ROWS    = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  REG_RESET_VALUE      = 8'd64;

    // Fixed-point constants (Q16.16)
    localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;
    localparam logic signed [31:0] ZERO_Q16 = 32'sh0000_0000;
    localparam logic signed [31:0] SAT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN  = 32'sh8000_0000;

    // Divider: 33-bit magnitude shifted up by 16 gives 49 quotient bits
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = 33;
    localparam int DIV_STEPS = DIFF_W + FRAC_BITS;

    // Width used to size the padded grid
    localparam int PAD_W = 13;

    typedef struct packed {
        logic signed [31:0] psi_value;
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
    } sample_t;

    typedef struct packed {
        logic [7:0]         cell_column;
        logic [7:0]         cell_row;
        logic signed [31:0] velocity_u;
        logic signed [31:0] velocity_v;
        logic               divide_fault;
        logic               frame_end;
    } result_t;

    // One pending result: either fixed or two quotients to work out
    typedef struct packed {
        logic                      compute;
        logic [7:0]                col;
        logic [7:0]                row;
        logic signed [31:0]        fixed_u;
        logic signed [DIFF_W-1:0]  num_u;
        logic signed [DIFF_W-1:0]  den_u;
        logic signed [DIFF_W-1:0]  num_v;
        logic signed [DIFF_W-1:0]  den_v;
        logic                      frame_end;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_READ_A,
        F_READ_B,
        F_READ_C,
        F_EMIT_A,
        F_EMIT_B,
        F_WRITE
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV_U,
        B_DIV_V,
        B_OUT
    } back_state_t;

    // Padded size: register clamped to 1..254, capped by capacity, plus two
    function automatic logic [PAD_W-1:0] padded_size(input logic [7:0] reg_value,
                                                      input logic [PAD_W-1:0] cap);
        logic [PAD_W-1:0] n;
        n = PAD_W'(reg_value);
        if (n < PAD_W'(1))
            n = PAD_W'(1);
        if (n > PAD_W'(254))
            n = PAD_W'(254);
        if (n + PAD_W'(2) > cap)
            n = cap - PAD_W'(2);
        return n + PAD_W'(2);
    endfunction

endpackage

// File: hdl/sfvs_ram.sv
// ============================================================================
// sfvs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module sfvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// File: hdl/sfvs_fifo.sv
// ============================================================================
// sfvs_fifo
// Small register FIFO used between the pipeline parts and at the output.
// ============================================================================
module sfvs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: hdl/sfvs_div.sv
// ============================================================================
// sfvs_div
// Serial signed Q16.16 divider, one quotient bit per cycle, saturating.
// ============================================================================
module sfvs_div
    import sfvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] num,
    input  logic signed [DIFF_W-1:0] den,
    output logic                     done,
    output logic signed [31:0]       quot,
    output logic                     fault
);

    localparam int ACC_W  = DIV_STEPS;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DIFF_W-1:0] rem_reg;
    logic [DIFF_W-1:0] dmag_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [DIFF_W-1:0] num_mag, den_mag;
    logic [DIFF_W:0]   trial;
    logic              qbit;
    logic [DIFF_W-1:0] rem_next;

    assign num_mag = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    assign den_mag = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

    // Restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, acc_reg[ACC_W-1]};
        qbit  = (trial >= {1'b0, dmag_reg});
        if (qbit)
            rem_next = DIFF_W'(trial - {1'b0, dmag_reg});
        else
            rem_next = trial[DIFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            acc_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            dmag_reg <= den_mag;
            neg_reg  <= num[DIFF_W-1] ^ den[DIFF_W-1];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[ACC_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    // Apply sign, saturate, force zero on a zero divisor
    always_comb
    begin
        if (zero_reg)
            quot = ZERO_Q16;
        else if (neg_reg)
            quot = (acc_reg > ACC_W'(64'h8000_0000)) ? SAT_MIN : -signed'(acc_reg[31:0]);
        else
            quot = (acc_reg > ACC_W'(64'h7FFF_FFFF)) ? SAT_MAX : signed'(acc_reg[31:0]);
    end

    assign done  = done_reg;
    assign fault = zero_reg;

endmodule

// File: hdl/sfvs_front.sv
// ============================================================================
// sfvs_front
// Accepts samples, keeps the row and coordinate stores, classifies each cell
// and queues up to two result jobs per sample.
// ============================================================================
module sfvs_front
    import sfvs_pkg::*;
#(
    parameter int MAX_PADDED_COLUMNS = DEF_MAX_PADDED_COLUMNS,
    parameter int MAX_PADDED_ROWS    = DEF_MAX_PADDED_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  sample_t                sample,
    output logic                   job_push,
    output job_t                   job_data,
    input  logic                   job_full
);

    localparam int CW     = $clog2(MAX_PADDED_COLUMNS);
    localparam int RW     = $clog2(MAX_PADDED_ROWS);
    localparam int PSI_AW = $clog2(2 * MAX_PADDED_COLUMNS);
    localparam logic [PSI_AW-1:0] ROW_OFS = PSI_AW'(MAX_PADDED_COLUMNS);

    front_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] cols_reg, rows_reg;
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    logic                  has_a_reg, has_b_reg;

    sample_t            item_reg;
    logic signed [31:0] hist0_reg, hist1_reg;
    logic signed [31:0] left_reg, right_reg, xm_reg, xp_reg;
    job_t               job_a_reg, job_b_reg;
    job_t               job_a_next, job_b_next;

    logic [CW:0]       width_pad;
    logic [RW:0]       height_pad;
    logic              first_col, last_col, last_row;
    logic [CW-1:0]     col_m1, col_p1;
    logic [CW:0]       col_p1x;
    logic [PSI_AW-1:0] cur_base, prev_base;

    logic [PSI_AW-1:0] psi_ra0, psi_ra1, psi_wa;
    logic [31:0]       psi_rd0, psi_rd1, x_rd0, x_rd1;
    logic              mem_we;
    logic              cfg_hit;

    // Grid geometry
    assign width_pad  = (CW + 1)'(padded_size(cols_reg, PAD_W'(MAX_PADDED_COLUMNS)));
    assign height_pad = (RW + 1)'(padded_size(rows_reg, PAD_W'(MAX_PADDED_ROWS)));
    assign first_col  = (col_reg == '0);
    assign last_col   = ({1'b0, col_reg} == width_pad - (CW + 1)'(1));
    assign last_row   = ({1'b0, row_reg} == height_pad - (RW + 1)'(1));
    assign col_m1     = first_col ? '0 : col_reg - CW'(1);
    assign col_p1x    = {1'b0, col_reg} + (CW + 1)'(1);
    assign col_p1     = (col_p1x >= (CW + 1)'(MAX_PADDED_COLUMNS)) ? '0 : col_p1x[CW-1:0];
    assign cur_base   = row_reg[0] ? ROW_OFS : '0;
    assign prev_base  = row_reg[0] ? '0 : ROW_OFS;
    assign cfg_hit    = cfg_we &&
                        (cfg_index == REG_INTERIOR_COLUMNS || cfg_index == REG_INTERIOR_ROWS);

    // Store addresses: neighbors of the previous row first, then the cell below
    assign psi_ra0 = (state_reg == F_READ_B) ? cur_base + PSI_AW'(col_reg)
                                             : prev_base + PSI_AW'(col_m1);
    assign psi_ra1 = prev_base + PSI_AW'(col_p1);
    assign psi_wa  = cur_base + PSI_AW'(col_reg);

    sfvs_ram #(
        .WIDTH (32),
        .DEPTH (2 * MAX_PADDED_COLUMNS)
    ) u_psi_ram (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (psi_wa),
        .wdata  (item_reg.psi_value),
        .raddr0 (psi_ra0),
        .rdata0 (psi_rd0),
        .raddr1 (psi_ra1),
        .rdata1 (psi_rd1)
    );

    sfvs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_PADDED_COLUMNS)
    ) u_x_ram (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (col_reg),
        .wdata  (item_reg.x_position),
        .raddr0 (col_m1),
        .rdata0 (x_rd0),
        .raddr1 (col_p1),
        .rdata1 (x_rd1)
    );

    // Classify the cell below and, on the top row, the top cell
    always_comb
    begin
        job_a_next           = '0;
        job_a_next.compute   = (row_reg != RW'(1)) && !first_col && !last_col;
        job_a_next.col       = 8'(col_reg);
        job_a_next.row       = 8'(row_reg - RW'(1));
        job_a_next.fixed_u   = ZERO_Q16;
        job_a_next.num_u     = {item_reg.psi_value[31], item_reg.psi_value}
                               - {psi_rd0[31], psi_rd0};
        job_a_next.den_u     = {item_reg.y_position[31], item_reg.y_position}
                               - {hist1_reg[31], hist1_reg};
        job_a_next.num_v     = {left_reg[31], left_reg} - {right_reg[31], right_reg};
        job_a_next.den_v     = {xp_reg[31], xp_reg} - {xm_reg[31], xm_reg};
        job_a_next.frame_end = 1'b0;

        job_b_next           = '0;
        job_b_next.compute   = 1'b0;
        job_b_next.col       = 8'(col_reg);
        job_b_next.row       = 8'(row_reg);
        job_b_next.fixed_u   = (!first_col && !last_col) ? ONE_Q16 : ZERO_Q16;
        job_b_next.frame_end = last_col;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:   if (push) state_next = F_READ_A;
            F_READ_A: state_next = F_READ_B;
            F_READ_B: state_next = F_READ_C;
            F_READ_C: state_next = F_EMIT_A;
            F_EMIT_A: if (!has_a_reg || !job_full) state_next = F_EMIT_B;
            F_EMIT_B: if (!has_b_reg || !job_full) state_next = F_WRITE;
            F_WRITE:  state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        full     = 1'b1;
        job_push = 1'b0;
        job_data = job_a_reg;
        mem_we   = 1'b0;
        unique case (state_reg)
            F_IDLE:   full = 1'b0;
            F_EMIT_A: job_push = has_a_reg && !job_full;
            F_EMIT_B:
            begin
                job_push = has_b_reg && !job_full;
                job_data = job_b_reg;
            end
            F_WRITE:  mem_we = 1'b1;
            default:  ;
        endcase
    end

    // Control state: configuration, counters, job flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cols_reg  <= REG_RESET_VALUE;
            rows_reg  <= REG_RESET_VALUE;
            col_reg   <= '0;
            row_reg   <= '0;
            has_a_reg <= 1'b0;
            has_b_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_INTERIOR_COLUMNS)
                cols_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_INTERIOR_ROWS)
                rows_reg <= cfg_data;
            if (state_reg == F_READ_C)
            begin
                has_a_reg <= (row_reg != '0);
                has_b_reg <= last_row;
            end
            // Restart the frame on a write to either size register, else advance the raster
            priority if (cfg_hit)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (state_reg == F_WRITE)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
            item_reg <= sample;
        if (state_reg == F_READ_B)
        begin
            left_reg  <= psi_rd0;
            right_reg <= psi_rd1;
            xm_reg    <= x_rd0;
            xp_reg    <= x_rd1;
        end
        if (state_reg == F_READ_C)
        begin
            job_a_reg <= job_a_next;
            job_b_reg <= job_b_next;
        end
        if (state_reg == F_WRITE && last_col)
        begin
            hist1_reg <= hist0_reg;
            hist0_reg <= item_reg.y_position;
        end
    end

endmodule

// File: hdl/sfvs_back.sv
// ============================================================================
// sfvs_back
// Takes queued jobs, runs both quotients of each compute job through the shared
// divider and hands finished results to the output queue.
// ============================================================================
module sfvs_back
    import sfvs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_empty,
    input  job_t    job_in,
    output logic    job_pop,
    output logic    res_push,
    output result_t res_data,
    input  logic    res_full
);

    back_state_t state_reg, state_next;

    job_t    job_reg;
    result_t res_reg;

    logic                     div_start;
    logic signed [DIFF_W-1:0] div_num, div_den;
    logic                     div_done;
    logic signed [31:0]       div_quot;
    logic                     div_fault;

    sfvs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .fault (div_fault)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                    state_next = job_in.compute ? B_DIV_U : B_OUT;
            end
            B_DIV_U:  if (div_done) state_next = B_DIV_V;
            B_DIV_V:  if (div_done) state_next = B_OUT;
            B_OUT:    if (!res_full) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        job_pop   = 1'b0;
        res_push  = 1'b0;
        div_start = 1'b0;
        div_num   = job_in.num_u;
        div_den   = job_in.den_u;
        unique case (state_reg)
            B_IDLE:
            begin
                job_pop   = !job_empty;
                div_start = !job_empty && job_in.compute;
            end
            B_DIV_U:
            begin
                div_start = div_done;
                div_num   = job_reg.num_v;
                div_den   = job_reg.den_v;
            end
            B_OUT:    res_push = !res_full;
            default:  ;
        endcase
    end

    assign res_data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    // Build the result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_reg              <= job_in;
                    res_reg.cell_column  <= job_in.col;
                    res_reg.cell_row     <= job_in.row;
                    res_reg.velocity_u   <= job_in.fixed_u;
                    res_reg.velocity_v   <= ZERO_Q16;
                    res_reg.divide_fault <= 1'b0;
                    res_reg.frame_end    <= job_in.frame_end;
                end
            end
            B_DIV_U:
            begin
                if (div_done)
                begin
                    res_reg.velocity_u   <= div_quot;
                    res_reg.divide_fault <= div_fault;
                end
            end
            B_DIV_V:
            begin
                if (div_done)
                begin
                    res_reg.velocity_v   <= div_quot;
                    res_reg.divide_fault <= res_reg.divide_fault | div_fault;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/stream_function_velocity_stencil.sv
// ============================================================================
// stream_function_velocity_stencil
// Velocity (u, v) from stream-function samples by central differences.
// ============================================================================
//  channel  | handshake       | payload
//  ---------+-----------------+------------------------------------------
//  samples  | push / full     | sample : psi_value, x_position, y_position
//  results  | pop / empty     | result : cell, velocity_u/v, flags
//  config   | cfg_we          | cfg_index, cfg_data (8 bits)
//
//  The front takes a new sample only after its read, emit and write states,
//  waiting while the job queue is full. Boundary results go from B_IDLE
//  straight to B_OUT; interior ones run B_DIV_U and B_DIV_V on the shared
//  one-bit-per-cycle divider (49 steps per quotient, two per cell). Reset
//  clears control state only; stores need no clearing pass. A full result
//  queue stalls the back, which stalls the front through the job queue.
module stream_function_velocity_stencil
    import sfvs_pkg::*;
#(
    parameter int MAX_PADDED_COLUMNS = DEF_MAX_PADDED_COLUMNS,
    parameter int MAX_PADDED_ROWS    = DEF_MAX_PADDED_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  sample_t                sample,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result
);

    logic    job_push, job_full, job_empty, job_pop;
    job_t    job_wdata, job_rdata;
    logic    res_push, res_full;
    result_t res_wdata;

    sfvs_front #(
        .MAX_PADDED_COLUMNS (MAX_PADDED_COLUMNS),
        .MAX_PADDED_ROWS    (MAX_PADDED_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .job_push  (job_push),
        .job_data  (job_wdata),
        .job_full  (job_full)
    );

    sfvs_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (2)
    ) u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_wdata),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_rdata),
        .empty (job_empty)
    );

    sfvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_in    (job_rdata),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res_data  (res_wdata),
        .res_full  (res_full)
    );

    sfvs_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

    // Jobs are only pushed into a queue with room
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
        else $error("job pushed into full queue");

    // Results are only pushed into a queue with room
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into full queue");

    // A zero-divisor fault always leaves one velocity at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.divide_fault) |->
        (result.velocity_u == ZERO_Q16 || result.velocity_v == ZERO_Q16))
        else $error("fault result with two nonzero velocities");

    // The frame ends only on a top-row corner, never on the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_end) |->
        (result.cell_row != 8'd0 && result.velocity_u == ZERO_Q16))
        else $error("frame end on wrong cell");

endmodule
